// ===== hdl/ppc_pkg.sv =====
// Package for the per-source IP packet counter: table sizing constants
// and the token type that travels along the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int INDEX_W     = 8;
    localparam int ENTRIES_W   = 9;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_W-1:0]    key;
        logic                 found;
        logic                 fresh;
        logic [COUNT_W-1:0]   count;
        logic [INDEX_W-1:0]   index;
        logic [USED_W-1:0]    used;
    } t_token;

endpackage

`default_nettype wire

// ===== hdl/ppc_cell.sv =====
// One table slot of the counter chain: stored address, count and occupancy.
// Compares the passing lookup beat, updates or claims the slot, and forwards it.
// Depends on ppc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppc_cell
    import ppc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [INDEX_W-1:0]   i_pos,
    input  t_token               i_tok,
    output t_token               o_tok
);

    logic [ADDR_W-1:0]  r_addr;
    logic [COUNT_W-1:0] r_count;
    logic               r_occ;
    t_token             r_tok;

    logic               live;
    logic               hit;
    logic               app;
    logic [COUNT_W-1:0] n_count;
    t_token             n_tok;

    always_comb begin
        live    = i_tok.valid & ~i_tok.found;
        hit     = live & r_occ & (r_addr == i_tok.key);
        app     = live & ~r_occ;
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_ONE;

        n_tok      = i_tok;
        n_tok.used = i_tok.used + USED_W'(r_occ | app);
        if (hit) begin
            n_tok.found = 1'b1;
            n_tok.count = n_count;
            n_tok.index = i_pos;
        end else if (app) begin
            n_tok.found = 1'b1;
            n_tok.fresh = 1'b1;
            n_tok.count = COUNT_ONE;
            n_tok.index = i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
            if (app) begin
                r_occ <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_count <= n_count;
        end else if (app) begin
            r_addr  <= i_tok.key;
            r_count <= COUNT_ONE;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== hdl/per_source_ip_packet_counter.sv =====
// Top level of the per-source IP packet counter: a row of ppc_cell slots
// that every lookup beat walks through. Depends on ppc_pkg and ppc_cell.
//
// A beat is taken on any cycle with start high and busy low; busy is high
// only while reset is held, so one address per cycle can be fed. Each beat
// walks the chain of TABLE_DEPTH slots, one slot per cycle, and its result
// appears with o_valid once it has passed the register of every slot, in
// order. The chain length sets the latency. The receiver cannot stall:
// o_valid is a one-cycle strobe and must be captured when it is high.
`timescale 1ns / 1ps
`default_nettype none

module per_source_ip_packet_counter
    import ppc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_W-1:0]     i_ip_addr,
    output logic                  o_valid,
    output logic [COUNT_W-1:0]    o_packet_count,
    output logic [INDEX_W-1:0]    o_entry_index,
    output logic                  o_new_entry,
    output logic                  o_table_full,
    output logic [ENTRIES_W-1:0]  o_entries_in_use
);

    t_token w_tok [TABLE_DEPTH+1];
    t_token head;
    t_token last;

    assign busy = ~i_rst_n;

    always_comb begin
        head       = '0;
        head.valid = start & ~busy;
        head.key   = i_ip_addr;
    end

    assign w_tok[0] = head;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ppc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (INDEX_W'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign last             = w_tok[TABLE_DEPTH];
    assign o_valid          = last.valid;
    assign o_packet_count   = last.count;
    assign o_entry_index    = last.index;
    assign o_new_entry      = last.fresh;
    assign o_table_full     = ~last.found;
    assign o_entries_in_use = ENTRIES_W'(last.used);

endmodule

`default_nettype wire
